// File: hdl/itra_pkg.sv
// Shared types and constants of the integer to radix ASCII converter.
package itra_pkg;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [5:0] TEN_BASE   = 6'd10;
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;

    // Controller to datapath commands
    typedef struct packed {
        logic idle;
        logic load;
        logic step;
        logic write_digit;
        logic emit_sign;
        logic fetch;
        logic emit_digit;
    } itra_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic count_full;
        logic sign_pending;
        logic out_free;
        logic last_digit;
    } itra_status_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIV   = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_LOAD  = 6'b100000
    } itra_state_t;

endpackage

// File: hdl/itra_if.sv
// Valid/ready channel interfaces for input values and output characters.
interface itra_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [5:0]  base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface itra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_char;

    modport source (output valid, output char_out, output last_char, input ready);
    modport sink   (input valid, input char_out, input last_char, output ready);
endinterface

// File: hdl/itra_ctrl.sv
// Sequencing state machine of the radix converter.
module itra_ctrl
    import itra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  itra_status_t st,
    output itra_cmd_t    cmd
);

    itra_state_t state_reg;
    itra_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.idle = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_digit = 1'b1;
                if (st.quot_zero || st.count_full)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                if (!st.sign_pending)
                begin
                    state_next = ST_FETCH;
                end
                else if (st.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    state_next     = st.last_digit ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/itra_datapath.sv
// Bit-serial divider, digit memory and output register of the radix converter.
module itra_datapath
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  itra_cmd_t    cmd,
    output itra_status_t st,
    input  logic [31:0]  value,
    input  logic [5:0]   base,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [7:0]   char_out,
    output logic         last_char
);

    localparam int BW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    logic [VALUE_BITS-1:0] q_reg;
    logic [5:0]            rem_reg;
    logic [5:0]            base_reg;
    logic [BW-1:0]         bit_cnt_reg;
    logic [CW-1:0]         count_reg;
    logic                  sign_reg;
    logic [5:0]            mem [MAX_DIGITS];
    logic [5:0]            rd_data_reg;
    logic                  out_valid_reg;
    logic [7:0]            char_reg;
    logic                  last_reg;

    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            base_sat;
    logic [6:0]            trial;
    logic                  ge;
    logic [5:0]            rem_next;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         count_dec;

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] c;
        if (d < TEN_BASE)
        begin
            c = 8'(CH_ZERO + {2'b00, d});
        end
        else
        begin
            c = 8'(CH_UPPER_A + {2'b00, d} - {2'b00, TEN_BASE});
        end
        return c;
    endfunction

    // Magnitude through unsigned negation so the most negative value survives
    assign raw = value[VALUE_BITS-1:0];
    assign neg = raw[VALUE_BITS-1];
    assign mag = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

    always_comb
    begin
        priority if (base < BASE_MIN)
        begin
            base_sat = BASE_MIN;
        end
        else if (base > BASE_MAX)
        begin
            base_sat = BASE_MAX;
        end
        else
        begin
            base_sat = base;
        end
    end

    // One restoring division step: shift in the next quotient bit
    assign trial    = {rem_reg, q_reg[VALUE_BITS-1]};
    assign ge       = trial >= {1'b0, base_reg};
    assign rem_next = ge ? 6'(trial - {1'b0, base_reg}) : trial[5:0];

    assign count_dec = count_reg - {{(CW-1){1'b0}}, 1'b1};
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = count_dec[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg       <= '0;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
            sign_reg    <= 1'b0;
        end
        else
        begin
            priority if (cmd.load)
            begin
                q_reg       <= mag;
                rem_reg     <= '0;
                bit_cnt_reg <= '0;
                count_reg   <= '0;
                sign_reg    <= neg && (base_sat == TEN_BASE);
            end
            else if (cmd.step)
            begin
                q_reg       <= {q_reg[VALUE_BITS-2:0], ge};
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg + {{(BW-1){1'b0}}, 1'b1};
            end
            else if (cmd.write_digit)
            begin
                rem_reg     <= '0;
                bit_cnt_reg <= '0;
                count_reg   <= count_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            else if (cmd.emit_digit)
            begin
                count_reg <= count_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= base_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_digit)
        begin
            mem[wr_addr] <= rem_reg;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.emit_sign)
        begin
            char_reg <= CH_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= digit_char(rd_data_reg);
            last_reg <= st.last_digit;
        end
    end

    assign st.div_last     = bit_cnt_reg == BW'(VALUE_BITS - 1);
    assign st.quot_zero    = q_reg == '0;
    assign st.count_full   = count_reg == CW'(MAX_DIGITS - 1);
    assign st.sign_pending = sign_reg;
    assign st.out_free     = !out_valid_reg || out_ready;
    assign st.last_digit   = count_reg == CW'(1);

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_reg || out_ready))
        else $error("output item overwritten while waiting");

    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_digit |-> (rem_reg < base_reg))
        else $error("remainder digit not below base");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (base_reg >= BASE_MIN && base_reg <= BASE_MAX))
        else $error("division with base out of range");

endmodule

// File: hdl/integer_to_radix_ascii_core.sv
// Top level of the integer to radix ASCII converter.
//
// Converts one signed value per input item into its ASCII digit string in a
// base from 2 to 36 (0-9 then A-Z), most significant digit first, one output
// item per character with last_char set on the final one. A leading minus
// sign is emitted only for negative values in base ten; other bases convert
// the magnitude alone. Zero gives "0"; bases below 2 or above 36 saturate.
// Sequence: a bit-serial restoring divider produces the remainder digits into
// the digit memory, then a sign check runs, then each character is fetched
// from the digit memory and loaded into the output register. A stall on the
// output side holds the sign and character steps. The next item is taken
// once the last character sits in the output register, even while that
// character still waits to be taken.
module integer_to_radix_ascii_core
    import itra_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    itra_in_if.sink           in_ch,
    itra_out_if.source        out_ch
);

    itra_cmd_t    cmd;
    itra_status_t st;

    // Accept a new item only when the sequencer is idle
    assign in_ch.ready = cmd.idle;

    itra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .st       (st),
        .cmd      (cmd)
    );

    itra_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .value     (in_ch.value),
        .base      (in_ch.base),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .char_out  (out_ch.char_out),
        .last_char (out_ch.last_char)
    );

endmodule

// File: dv/radix_string_checker.sv
// Checker of the radix converter: predicts each character string and compares the output items.
module radix_string_checker
    import itra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    itra_in_if         in_mon,
    itra_out_if        out_mon,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } radix_char_t;

    radix_char_t expected_chars[$];

    function automatic logic [7:0] digit_to_ascii(input logic [5:0] d);
        if (d < 6'd10)
        begin
            return CH_ZERO + {2'b00, d};
        end
        return CH_UPPER_A + {2'b00, d - 6'd10};
    endfunction

    // Append the string for one value, sign first, most significant digit next.
    function automatic void predict_radix_string(input logic [31:0] v, input logic [5:0] b_in);
        logic [5:0]  b;
        logic [31:0] quot;
        logic [5:0]  digits[32];
        int          n;
        logic        neg;
        radix_char_t c;
        b = b_in;
        if (b < BASE_MIN)
        begin
            b = BASE_MIN;
        end
        if (b > BASE_MAX)
        begin
            b = BASE_MAX;
        end
        neg  = v[31];
        quot = neg ? (~v + 32'd1) : v;
        n    = 0;
        do
        begin
            digits[n] = 6'(quot % {26'd0, b});
            quot      = quot / {26'd0, b};
            n++;
        end
        while (quot != 32'd0 && n < 32);
        if (neg && b == TEN_BASE)
        begin
            c.ch   = CH_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            c.ch   = digit_to_ascii(digits[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        radix_char_t want;
        if (rst_n)
        begin
            // Retire the output first: it can never belong to an item accepted on this edge.
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected char expected none, actual %h last %b",
                             $time, out_mon.char_out, out_mon.last_char);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_mon.char_out !== want.ch || out_mon.last_char !== want.last)
                    begin
                        $display("%0t: char mismatch expected %h last %b, actual %h last %b",
                                 $time, want.ch, want.last, out_mon.char_out,
                                 out_mon.last_char);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                predict_radix_string(in_mon.value, in_mon.base);
            end
        end
        pending <= expected_chars.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the radix converter testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Timeout: well above the slowest legal run (every item 32 digits, long sink stalls).
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_ITEMS  = 460;
    localparam int TAIL_CYCLES   = 80;

    logic clk = 1'b0;
    logic rst_n;
    int   idle_pct;
    int   fail_count;
    int   pending;
    int   watchdog_cycles;

    itra_in_if  in_ch();
    itra_out_if out_ch();

    integer_to_radix_ascii_core uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    radix_string_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // Stall the character sink at random, at the same rate as the sender idles.
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Drop the run if it never finishes.
    initial
    begin
        watchdog_cycles = 0;
        while (watchdog_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one item, idling at random first; return on the edge that accepts it.
    task automatic send_value(input logic [31:0] v, input logic [5:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.base  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
    endtask

    // Hold the sender until every predicted character has come out.
    task automatic drain_output();
        in_ch.valid <= 1'b0;
        // Let the checker register the item just accepted before pending is read.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] v;
        logic [5:0]  b;
        int          pick;

        rst_n        <= 1'b0;
        idle_pct     <= 37;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        in_ch.base   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero, all-ones, both extremes of the value range,
        // the extreme digits, the minus sign in base ten only, and saturated bases.
        send_value(32'd0,          6'd10);
        send_value(32'd0,          6'd2);
        send_value(32'hFFFF_FFFF,  6'd10);
        send_value(32'hFFFF_FFFF,  6'd16);
        send_value(32'h7FFF_FFFF,  6'd2);
        send_value(32'h7FFF_FFFF,  6'd36);
        send_value(32'h8000_0000,  6'd10);
        send_value(32'h8000_0000,  6'd2);
        send_value(32'h8000_0000,  6'd36);
        send_value(32'h7FFF_FFFF,  6'd10);
        send_value(32'd35,         6'd36);
        send_value(32'd36,         6'd36);
        send_value(32'd9,          6'd10);
        send_value(32'd10,         6'd16);
        send_value(32'd1,          6'd2);
        send_value(-32'sd123,      6'd10);
        send_value(-32'sd255,      6'd16);
        send_value(32'd255,        6'd16);
        send_value(32'd5,          6'd0);
        send_value(32'd5,          6'd1);
        send_value(32'd100,        6'd37);
        send_value(32'd12345,      6'd63);
        send_value(-32'sd7,        6'd63);
        send_value(-32'sd1000,     6'd0);

        // Random part: mostly short strings, a fifth at full width.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Long stretch with both sides running flat out.
            if (i == 150)
            begin
                idle_pct <= 0;
            end
            if (i == 230)
            begin
                idle_pct <= 37;
            end
            if (i == 300)
            begin
                drain_output();
            end

            pick = $urandom_range(99);
            if (pick < 20)
            begin
                v = $urandom;
            end
            else if (pick < 55)
            begin
                v = 32'($urandom_range(2000)) - 32'd1000;
            end
            else if (pick < 80)
            begin
                v = 32'($urandom_range(65535)) - 32'd32768;
            end
            else
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                begin
                    v = ~v + 32'd1;
                end
            end

            pick = $urandom_range(99);
            if (pick < 75)
            begin
                b = 6'($urandom_range(36, 2));
            end
            else if (pick < 88)
            begin
                b = 6'd10;
            end
            else
            begin
                b = 6'($urandom_range(63));
            end

            send_value(v, b);
        end

        // Wait out every expected character, then a margin for strays.
        drain_output();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
